// ===== design/adc_scan_millivolt_ascii_report_unit_assert.svh =====
// Assertion macros shared by the checker of the millivolt report unit.
`ifndef ADC_SCAN_MILLIVOLT_ASCII_REPORT_UNIT_ASSERT_SVH
`define ADC_SCAN_MILLIVOLT_ASCII_REPORT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADCMV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADCMV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/adcmv_pkg.sv =====
// Package with constants, state type and character table of the millivolt report unit.
`default_nettype none

package adcmv_pkg;

   // Default sizes of the top level.
   localparam int NUM_CHANNELS_DEF = 4;
   localparam int SAMPLE_BITS_DEF  = 12;

   // Millivolt value and reference register.
   localparam int              MV_W      = 14;
   localparam logic [MV_W-1:0] REF_RESET = 14'd3300;
   localparam logic [MV_W-1:0] REF_MAX   = 14'd9999;

   // Report line.
   localparam int        REPORT_LEN = 10;
   localparam int        CHAN_W     = 3;
   localparam int        BCD_W      = 16;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_V     = 8'h56;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_POINT = 8'h2E;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_LF    = 8'h0A;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_BCD,
      ST_EMIT
   } adcmv_state_type;

   // Character at a given position of the report line, from four BCD digits.
   function automatic logic [7:0] report_char(input logic [3:0] pos,
                                              input logic [BCD_W-1:0] bcd);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = ASCII_V;
         4'd1:    ch = ASCII_SPACE;
         4'd2:    ch = ASCII_ZERO + {4'd0, bcd[15:12]};
         4'd3:    ch = ASCII_POINT;
         4'd4:    ch = ASCII_ZERO + {4'd0, bcd[11:8]};
         4'd5:    ch = ASCII_ZERO + {4'd0, bcd[7:4]};
         4'd6:    ch = ASCII_ZERO + {4'd0, bcd[3:0]};
         4'd7:    ch = ASCII_SPACE;
         4'd8:    ch = ASCII_CR;
         4'd9:    ch = ASCII_LF;
         default: ch = ASCII_SPACE;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== design/adc_scan_millivolt_ascii_report_unit.sv =====
// Top level of the scan reporter: scales a sample to millivolts and streams an ASCII line.
//
//   Channel   Direction  Payload
//   req_      in         tdata: sample_value
//   rsp_      out        tdata: tx_byte, tlast: last_byte, tuser: sample_channel
//   csr_      in         wdata: reference_millivolts (saturated to 9999)
//
// A sample passes through an accept in idle, SAMPLE_BITS shift-add multiply steps,
// 14 restoring divide steps, 14 double-dabble steps and the ten bytes of the line.
// A single shared step counter sequences every phase and the datapath handles one bit
// per cycle; a new sample is taken only in idle.
// Reset is synchronous, clears the sequencer and scan channel and sets the reference to 3300.
// A stalled output holds its byte; the sequencer waits in the byte phase.
`default_nettype none

module adc_scan_millivolt_ascii_report_unit
   import adcmv_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   localparam int REQ_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // [SAMPLE_BITS-1:0] sample_value, rest zero
   // Response channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] tx_byte
   output logic                   rsp_tlast,
   output logic [CHAN_W-1:0]      rsp_tuser,   // [2:0] sample_channel
   // Configuration.
   input  wire logic              csr_wen,
   input  wire logic [MV_W-1:0]   csr_wdata
);

   localparam int PW       = SAMPLE_BITS + MV_W;
   localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int STEP_MAX = (SAMPLE_BITS > MV_W) ? SAMPLE_BITS : MV_W;
   localparam int CNT_W    = $clog2(STEP_MAX);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

   adcmv_state_type          state_ff, state_in;
   logic [MV_W-1:0]          ref_ff;
   logic [CH_W-1:0]          scan_ff, scan_in;
   logic [CHAN_W-1:0]        chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0]   smp_ff, smp_in;
   logic [PW-1:0]            acc_ff, acc_in;
   logic [BCD_W-1:0]         bcd_ff, bcd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic                     req_take;
   logic                     rsp_take;
   logic                     last_step;
   logic [4:0]               scan_inc;
   logic [SAMPLE_BITS:0]     div_cat;
   logic [SAMPLE_BITS+1:0]   div_diff;
   logic                     div_qbit;
   logic [SAMPLE_BITS-1:0]   div_rem;
   logic [BCD_W-1:0]         bcd_adj;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign scan_inc = 5'(scan_ff) + 5'd1;

   // End of the current phase, compared against the phase length.
   always_comb begin
      case (state_ff)
         ST_MUL:  last_step = (cnt_ff == CNT_W'(SAMPLE_BITS - 1));
         ST_DIV:  last_step = (cnt_ff == CNT_W'(MV_W - 1));
         ST_BCD:  last_step = (cnt_ff == CNT_W'(MV_W - 1));
         ST_EMIT: last_step = (cnt_ff == CNT_W'(REPORT_LEN - 1));
         default: last_step = 1'b0;
      endcase
   end

   // One restoring divide step by the full-scale code; the remainder stays below it.
   always_comb begin
      div_cat  = {acc_ff[PW-1:MV_W], acc_ff[MV_W-1]};
      div_diff = {1'b0, div_cat} - {2'b00, FULL_SCALE};
      div_qbit = !div_diff[SAMPLE_BITS+1];
      div_rem  = div_qbit ? div_diff[SAMPLE_BITS-1:0] : div_cat[SAMPLE_BITS-1:0];
   end

   // Double-dabble correction on each BCD digit before the shift.
   always_comb begin
      for (int i = 0; i < BCD_W / 4; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                        : bcd_ff[i*4 +: 4];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take)  state_in = ST_MUL;
         ST_MUL:  if (last_step) state_in = ST_DIV;
         ST_DIV:  if (last_step) state_in = ST_BCD;
         ST_BCD:  if (last_step) state_in = ST_EMIT;
         ST_EMIT: if (rsp_take && last_step) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs and datapath updates per state.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      scan_in    = scan_ff;
      chan_in    = chan_ff;
      smp_in     = smp_ff;
      acc_in     = acc_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               smp_in  = req_tdata[SAMPLE_BITS-1:0];
               acc_in  = '0;
               cnt_in  = '0;
               chan_in = scan_inc[CHAN_W-1:0];
               scan_in = (scan_inc >= 5'(NUM_CHANNELS)) ? '0 : scan_inc[CH_W-1:0];
            end
         end
         ST_MUL: begin
            // Sample bits enter most significant first.
            acc_in = {acc_ff[PW-2:0], 1'b0} + (smp_ff[SAMPLE_BITS-1] ? PW'(ref_ff) : '0);
            smp_in = {smp_ff[SAMPLE_BITS-2:0], 1'b0};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         ST_DIV: begin
            // Quotient bits shift in at the bottom as dividend bits leave the top.
            acc_in = {div_rem, acc_ff[MV_W-2:0], div_qbit};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
            if (last_step) bcd_in = '0;
         end
         ST_BCD: begin
            bcd_in = {bcd_adj[BCD_W-2:0], acc_ff[MV_W-1]};
            acc_in = {acc_ff[PW-2:0], 1'b0};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_take) cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Response payload comes from the held digits and byte position.
   assign rsp_tdata = report_char(4'(cnt_ff), bcd_ff);
   assign rsp_tlast = (cnt_ff == CNT_W'(REPORT_LEN - 1));
   assign rsp_tuser = chan_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Reference register; values above the largest reportable voltage saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_wen) begin
         ref_ff <= (csr_wdata > REF_MAX) ? REF_MAX : csr_wdata;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      smp_ff  <= smp_in;
      acc_ff  <= acc_in;
      bcd_ff  <= bcd_in;
   end

endmodule

`default_nettype wire

// ===== design/adcmv_checker.sv =====
// Port-level checker of the millivolt report unit and its bind statement.
`default_nettype none
`include "adc_scan_millivolt_ascii_report_unit_assert.svh"

module adcmv_checker
   import adcmv_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [7:0]        rsp_tdata,
   input wire logic              rsp_tlast,
   input wire logic [CHAN_W-1:0] rsp_tuser
);

   // No new request is taken while a report line is being sent.
   `ADCMV_ASSERT_SAME(a_no_req_during_rsp, clock, reset, rsp_tvalid, !req_tready, "request taken during report")

   // A report cannot start right after the request that causes it.
   `ADCMV_ASSERT_NEXT(a_rsp_not_immediate, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "report too early")

   // Within one line the bytes follow without gaps and carry one channel.
   `ADCMV_ASSERT_NEXT(a_line_channel, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && $stable(rsp_tuser), "line broken or channel changed")

   // The line ends on a line feed.
   `ADCMV_ASSERT_SAME(a_last_is_lf, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == ASCII_LF, "last byte is not a line feed")

endmodule

bind adc_scan_millivolt_ascii_report_unit adcmv_checker u_adcmv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the scan reporter: sample requests in, ASCII voltage lines out.
module tb_top;
   import adcmv_pkg::*;

   localparam int REQ_W          = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int FULL_SCALE     = (1 << SAMPLE_BITS_DEF) - 1;
   localparam int DRAIN_CYCLES   = SAMPLE_BITS_DEF + 49;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 9;
   localparam int PHASE_ITEMS    = 50;
   localparam int NUM_DIRECTED   = 25;
   localparam int PREDICT_MV     = -1;

   typedef enum {ROW_WRITE_REF, ROW_SAMPLE} row_kind_type;

   // One directed step: a reference write or a sample, with the millivolt value typed in
   // where it is obvious, else PREDICT_MV.
   typedef struct {
      row_kind_type kind;
      int           value;
      int           want_mv;
   } directed_row_type;

   typedef struct {
      logic [7:0]        tx_byte;
      logic              last_byte;
      logic [CHAN_W-1:0] channel;
   } report_byte_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // [11:0] sample_value, rest zero
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [7:0]          rsp_tdata;   // [7:0] tx_byte
   logic                rsp_tlast;
   logic [CHAN_W-1:0]   rsp_tuser;   // [2:0] sample_channel
   logic                csr_wen;
   logic [MV_W-1:0]     csr_wdata;

   report_byte_type     expected_bytes [$];
   int unsigned         reference_mv;
   int unsigned         next_channel_idx;
   int                  mismatch_count = 0;
   int                  stall_count = 0;
   bit                  tx_idling;
   bit                  rx_idling;
   int                  hold_off_cycles = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_SAMPLE,    4095, 3300},
      '{ROW_SAMPLE,    0,    0},
      '{ROW_SAMPLE,    2048, PREDICT_MV},
      '{ROW_SAMPLE,    1,    0},
      '{ROW_WRITE_REF, 16383, 0},
      '{ROW_SAMPLE,    4095, 9999},
      '{ROW_SAMPLE,    4094, PREDICT_MV},
      '{ROW_WRITE_REF, 10000, 0},
      '{ROW_SAMPLE,    4095, 9999},
      '{ROW_WRITE_REF, 0,    0},
      '{ROW_SAMPLE,    4095, 0},
      '{ROW_SAMPLE,    2730, 0},
      '{ROW_WRITE_REF, 9999, 0},
      '{ROW_SAMPLE,    2730, PREDICT_MV},
      '{ROW_SAMPLE,    1365, PREDICT_MV},
      '{ROW_WRITE_REF, 1,    0},
      '{ROW_SAMPLE,    4095, 1},
      '{ROW_SAMPLE,    4094, 0},
      '{ROW_WRITE_REF, 4095, 0},
      '{ROW_SAMPLE,    1234, 1234},
      '{ROW_SAMPLE,    3210, 3210},
      '{ROW_SAMPLE,    4095, 4095},
      '{ROW_WRITE_REF, 8191, 0},
      '{ROW_SAMPLE,    3000, PREDICT_MV},
      '{ROW_WRITE_REF, 3300, 0}
   };

   adc_scan_millivolt_ascii_report_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Scales one sample, builds its report line and advances the scan channel.
   function automatic void predict_report_line(input logic [11:0] sample, input int want_mv);
      int unsigned mv;
      logic [CHAN_W-1:0] chan;
      logic [7:0] line [REPORT_LEN];
      mv = (32'(sample) * reference_mv) / FULL_SCALE;
      if (mv > REF_MAX) mv = REF_MAX;
      if (want_mv != PREDICT_MV) mv = want_mv;
      chan = CHAN_W'(next_channel_idx + 1);
      if (next_channel_idx + 1 >= NUM_CHANNELS_DEF) begin
         next_channel_idx = 0;
      end else begin
         next_channel_idx = next_channel_idx + 1;
      end
      line = '{ASCII_V, ASCII_SPACE, ASCII_ZERO + 8'((mv / 1000) % 10), ASCII_POINT,
               ASCII_ZERO + 8'((mv / 100) % 10), ASCII_ZERO + 8'((mv / 10) % 10),
               ASCII_ZERO + 8'(mv % 10), ASCII_SPACE, ASCII_CR, ASCII_LF};
      for (int k = 0; k < REPORT_LEN; k++) begin
         expected_bytes.push_back('{line[k], k == REPORT_LEN - 1, chan});
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offers one sample request and waits until the block takes it.
   task automatic send_sample(input logic [11:0] sample, input int want_mv);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample);
      do @(posedge clock); while (!req_tready);
      predict_report_line(sample, want_mv);
   endtask

   task automatic req_gap(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stops offering requests and waits for every pending report byte.
   task automatic drain_reports();
      req_gap(1);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Reference writes happen only with the block idle.
   task automatic write_reference(input int unsigned value);
      drain_reports();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= MV_W'(value);
      @(negedge clock);
      csr_wen   <= 1'b0;
      reference_mv = (value > REF_MAX) ? REF_MAX : value;
   endtask

   function automatic int unsigned pick_reference(input int phase);
      case (phase)
         0:       return REF_MAX;
         1:       return 0;
         2:       return 16383;
         3:       return REF_RESET;
         4:       return $urandom_range(1, 20);
         default: return $urandom_range(0, 1) ? $urandom_range(0, 16383)
                                              : $urandom_range(0, REF_MAX);
      endcase
   endfunction

   function automatic logic [11:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 12'd0;
         1:       return 12'hFFF;
         2:       return 12'($urandom_range(4000, 4095));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Response side: random stall bursts while rx_idling is set, plus one long hold-off once it is requested.
   initial begin : rsp_driver
      int stall_left;
      bit hold_off_done;
      stall_left    = 0;
      hold_off_done = 1'b0;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_cycles > 0 && !hold_off_done) begin
            stall_left    = hold_off_cycles - 1;
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
         end else if (rx_idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every accepted response byte with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      report_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("response byte with no request pending", rsp_tdata, 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.tx_byte)
               report_mismatch("tx_byte", rsp_tdata, want.tx_byte);
            if (rsp_tlast !== want.last_byte)
               report_mismatch("last_byte", rsp_tlast, want.last_byte);
            if (rsp_tuser !== want.channel)
               report_mismatch("sample_channel", rsp_tuser, want.channel);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count = 0;
      end else begin
         stall_count++;
      end
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_wen          = 1'b0;
      csr_wdata        = '0;
      reference_mv     = REF_RESET;
      next_channel_idx = 0;
      tx_idling        = 1'b1;
      rx_idling        = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE_REF) begin
            write_reference(directed_rows[r].value);
         end else begin
            send_sample(12'(directed_rows[r].value), directed_rows[r].want_mv);
         end
      end

      // Random phases, each under its own reference setting; the last one runs without gaps.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_reference(pick_reference(phase));
         tx_idling = (phase != NUM_PHASES - 1);
         rx_idling = (phase != NUM_PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Long receiver hold-off while requests keep coming, to back up the input.
            if (phase == 2 && i == 5) hold_off_cycles = 300;
            // Sender waits until the block has delivered everything.
            if (phase == 4 && i == 25) drain_reports();
            if (tx_idling && $urandom_range(0, 3) == 0) req_gap($urandom_range(1, 8));
            send_sample(pick_sample(), PREDICT_MV);
         end
      end

      drain_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/adcmv_pkg.sv
design/adc_scan_millivolt_ascii_report_unit.sv
design/adcmv_checker.sv
test/tb_top.sv
